@@ hdl/dik_pkg.sv @@
// ----------------------------------------------------------------------------
// dik_pkg
// Types, constants and register indexes of the delta inverse kinematics unit.
// ----------------------------------------------------------------------------
package dik_pkg;

	localparam int unsigned CoordW     = 20;
	localparam int unsigned StepsW     = 25;
	localparam int unsigned SpmW       = 24;
	localparam int unsigned RodW       = 40;
	localparam int unsigned GeoW       = 64;
	localparam int unsigned CfgIdxW    = 3;
	localparam int unsigned RootW      = 28;
	localparam int unsigned RadW       = 2 * RootW;
	localparam int unsigned RemW       = RootW + 3;
	localparam int unsigned OpW        = 30;
	localparam int unsigned ProdW      = OpW + SpmW + 1;
	// three front stages, one sqrt stage per root bit, then h, multiply, round
	localparam int unsigned PipeDepth  = RootW + 6;

	localparam logic signed [StepsW-1:0] StepMax = 25'sd16777215;
	localparam logic signed [StepsW-1:0] StepMin = -25'sd16777216;

	typedef enum logic [CfgIdxW-1:0] {
		REG_GEO_A = 3'd0,
		REG_GEO_B = 3'd1,
		REG_GEO_C = 3'd2,
		REG_ROD_A = 3'd3,
		REG_ROD_B = 3'd4,
		REG_ROD_C = 3'd5
	} dik_reg_t;

	typedef enum logic [1:0] {
		REACH_OK = 2'd0,
		REACH_A  = 2'd1,
		REACH_B  = 2'd2,
		REACH_C  = 2'd3
	} dik_reach_t;

	// word travelling through one sqrt iteration
	typedef struct packed {
		logic [RemW-1:0]          rem;
		logic [RootW-1:0]         root;
		logic [RadW-1:0]          rad;
		logic                     neg;
		logic signed [CoordW-1:0] pz;
		logic signed [CoordW-1:0] coord;
		logic                     per_axis;
	} dik_sq_t;

	typedef struct packed {
		logic signed [StepsW-1:0] steps;
		logic                     neg;
		logic                     per_axis;
	} dik_lane_out_t;

endpackage

@@ hdl/dik_if.sv @@
// ----------------------------------------------------------------------------
// dik_if
// Valid/ready channels for positions in and step counts out.
// ----------------------------------------------------------------------------
interface dik_pos_if;
	logic                              valid;
	logic                              ready;
	logic signed [dik_pkg::CoordW-1:0] position_x;
	logic signed [dik_pkg::CoordW-1:0] position_y;
	logic signed [dik_pkg::CoordW-1:0] position_z;
	logic                              per_axis_mode;

	modport source (output valid, position_x, position_y, position_z, per_axis_mode,
		input ready);
	modport sink (input valid, position_x, position_y, position_z, per_axis_mode,
		output ready);
endinterface

interface dik_steps_if;
	logic                              valid;
	logic                              ready;
	logic signed [dik_pkg::StepsW-1:0] steps_a;
	logic signed [dik_pkg::StepsW-1:0] steps_b;
	logic signed [dik_pkg::StepsW-1:0] steps_c;
	logic [1:0]                        reach_status;

	modport source (output valid, steps_a, steps_b, steps_c, reach_status, input ready);
	modport sink (input valid, steps_a, steps_b, steps_c, reach_status, output ready);
endinterface

@@ hdl/dik_sqrt_stage.sv @@
// ----------------------------------------------------------------------------
// dik_sqrt_stage
// One registered iteration of the digit-by-digit square root.
// ----------------------------------------------------------------------------
module dik_sqrt_stage (
	input  logic             clk,
	input  logic             en,
	input  dik_pkg::dik_sq_t d,
	output dik_pkg::dik_sq_t sq_s1
);

	logic [dik_pkg::RemW-1:0] rem_sh;
	logic [dik_pkg::RemW-1:0] trial;
	dik_pkg::dik_sq_t         nxt;

	always_comb begin
		nxt    = d;
		rem_sh = {d.rem[dik_pkg::RemW-3:0], d.rad[dik_pkg::RadW-1 -: 2]};
		trial  = {1'b0, d.root, 2'b01};
		nxt.rad = {d.rad[dik_pkg::RadW-3:0], 2'b00};
		if (rem_sh >= trial) begin
			nxt.rem  = rem_sh - trial;
			nxt.root = {d.root[dik_pkg::RootW-2:0], 1'b1};
		end else begin
			nxt.rem  = rem_sh;
			nxt.root = {d.root[dik_pkg::RootW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1 <= nxt;
		end
	end

endmodule

@@ hdl/dik_lane.sv @@
// ----------------------------------------------------------------------------
// dik_lane
// One tower: discriminant, pipelined square root, scale by steps per mm, round.
// ----------------------------------------------------------------------------
module dik_lane (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [dik_pkg::CoordW-1:0] px,
	input  logic signed [dik_pkg::CoordW-1:0] py,
	input  logic signed [dik_pkg::CoordW-1:0] pz,
	input  logic signed [dik_pkg::CoordW-1:0] coord,
	input  logic                              per_axis,
	input  logic [dik_pkg::GeoW-1:0]          geo,
	input  logic [dik_pkg::RodW-1:0]          rod_sq,
	output dik_pkg::dik_lane_out_t            res
);

	localparam int unsigned DW = dik_pkg::CoordW + 1;
	localparam int unsigned SqW = 2 * DW;
	localparam int unsigned DiscW = dik_pkg::RodW + 3;

	logic signed [DW-1:0]               dx_s1, dy_s1;
	logic signed [dik_pkg::CoordW-1:0]  pz_s1, coord_s1, pz_s2, coord_s2;
	logic                               mode_s1, mode_s2;
	logic signed [SqW-1:0]              dx2_s2, dy2_s2;
	logic signed [DiscW-1:0]            disc;
	dik_pkg::dik_sq_t                   sq_s3;
	dik_pkg::dik_sq_t                   chain [dik_pkg::RootW+1];
	logic signed [dik_pkg::OpW-1:0]     h;
	logic signed [dik_pkg::OpW-1:0]     op_s32;
	logic                               mode_s32, neg_s32, mode_s33, neg_s33;
	logic signed [dik_pkg::ProdW-1:0]   prod_s33;
	logic [dik_pkg::ProdW-1:0]          mag, rsum, q;
	logic signed [dik_pkg::StepsW-1:0]  steps;
	dik_pkg::dik_sq_t                   last;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1    <= DW'($signed(geo[63:44])) - DW'(px);
			dy_s1    <= DW'($signed(geo[43:24])) - DW'(py);
			pz_s1    <= pz;
			coord_s1 <= coord;
			mode_s1  <= per_axis;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx2_s2   <= dx_s1 * dx_s1;
			dy2_s2   <= dy_s1 * dy_s1;
			pz_s2    <= pz_s1;
			coord_s2 <= coord_s1;
			mode_s2  <= mode_s1;
		end
	end

	assign disc = $signed({3'b000, rod_sq}) - DiscW'(dx2_s2) - DiscW'(dy2_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3.rem      <= '0;
			sq_s3.root     <= '0;
			sq_s3.rad      <= {disc[dik_pkg::RodW-1:0], 16'h0000};
			sq_s3.neg      <= disc[DiscW-1];
			sq_s3.pz       <= pz_s2;
			sq_s3.coord    <= coord_s2;
			sq_s3.per_axis <= mode_s2;
		end
	end

	assign chain[0] = sq_s3;

	for (genvar i = 0; i < dik_pkg::RootW; i++) begin : g_sqrt
		dik_sqrt_stage u_stage (
			.clk  (clk),
			.en   (en),
			.d    (chain[i]),
			.sq_s1(chain[i+1])
		);
	end

	assign last = chain[dik_pkg::RootW];
	assign h = $signed({2'b00, last.root}) + (dik_pkg::OpW'(last.pz) <<< 8);

	always_ff @(posedge clk) begin
		if (en) begin
			op_s32   <= last.per_axis ? dik_pkg::OpW'(last.coord) : h;
			mode_s32 <= last.per_axis;
			neg_s32  <= last.neg;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s33 <= op_s32 * $signed({1'b0, geo[dik_pkg::SpmW-1:0]});
			mode_s33 <= mode_s32;
			neg_s33  <= neg_s32;
		end
	end

	// round half away from zero on the magnitude, then saturate
	always_comb begin
		mag  = prod_s33[dik_pkg::ProdW-1] ? dik_pkg::ProdW'(-prod_s33)
			: dik_pkg::ProdW'(prod_s33);
		rsum = mag + (mode_s33 ? dik_pkg::ProdW'(1 << 19) : dik_pkg::ProdW'(1 << 27));
		q    = mode_s33 ? (rsum >> 20) : (rsum >> 28);
		if (prod_s33[dik_pkg::ProdW-1]) begin
			steps = (q > dik_pkg::ProdW'(16777216)) ? dik_pkg::StepMin
				: -$signed(q[dik_pkg::StepsW-1:0]);
		end else begin
			steps = (q > dik_pkg::ProdW'(16777215)) ? dik_pkg::StepMax
				: $signed(q[dik_pkg::StepsW-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res.steps    <= steps;
			res.neg      <= neg_s33;
			res.per_axis <= mode_s33;
		end
	end

endmodule

@@ hdl/delta_inverse_kinematics_steps_unit.sv @@
// ----------------------------------------------------------------------------
// delta_inverse_kinematics_steps_unit
// Three tower lanes of delta inverse kinematics with a valid/ready wrapper.
// ----------------------------------------------------------------------------
// a position passes each lane's front, sqrt, h, multiply and round stages, then the output register
// throughput: one position per cycle while the output register is free, set by one sqrt stage per root bit
// the whole pipe advances together while the output register is free
// reset clears the valid bits and all six configuration registers
module delta_inverse_kinematics_steps_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [dik_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [dik_pkg::GeoW-1:0]           cfg_wdata,
	dik_pos_if.sink                            pos_in,
	dik_steps_if.source                        steps_out
);

	logic [dik_pkg::GeoW-1:0]       geo_q [3];
	logic [dik_pkg::RodW-1:0]       rod_q [3];
	logic [dik_pkg::PipeDepth-1:0]  vld_q;
	logic                           adv;
	dik_pkg::dik_lane_out_t         lane_res [3];
	logic signed [dik_pkg::CoordW-1:0] lane_coord [3];
	logic                           out_valid_q;
	logic signed [dik_pkg::StepsW-1:0] steps_a_q, steps_b_q, steps_c_q;
	dik_pkg::dik_reach_t            status_q, status;
	logic                           na, nb, nc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				geo_q[i] <= '0;
				rod_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (dik_pkg::dik_reg_t'(cfg_index))
				dik_pkg::REG_GEO_A: geo_q[0] <= cfg_wdata;
				dik_pkg::REG_GEO_B: geo_q[1] <= cfg_wdata;
				dik_pkg::REG_GEO_C: geo_q[2] <= cfg_wdata;
				dik_pkg::REG_ROD_A: rod_q[0] <= cfg_wdata[dik_pkg::RodW-1:0];
				dik_pkg::REG_ROD_B: rod_q[1] <= cfg_wdata[dik_pkg::RodW-1:0];
				dik_pkg::REG_ROD_C: rod_q[2] <= cfg_wdata[dik_pkg::RodW-1:0];
				default: ;
			endcase
		end
	end

	assign adv = !out_valid_q || steps_out.ready;
	assign pos_in.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[dik_pkg::PipeDepth-2:0], pos_in.valid};
		end
	end

	assign lane_coord[0] = pos_in.position_x;
	assign lane_coord[1] = pos_in.position_y;
	assign lane_coord[2] = pos_in.position_z;

	for (genvar t = 0; t < 3; t++) begin : g_lane
		dik_lane u_lane (
			.clk     (clk),
			.en      (adv),
			.px      (pos_in.position_x),
			.py      (pos_in.position_y),
			.pz      (pos_in.position_z),
			.coord   (lane_coord[t]),
			.per_axis(pos_in.per_axis_mode),
			.geo     (geo_q[t]),
			.rod_sq  (rod_q[t]),
			.res     (lane_res[t])
		);
	end

	// outside per-axis mode, the first unreachable tower zeroes itself and every later tower
	assign na = !lane_res[0].per_axis && lane_res[0].neg;
	assign nb = !lane_res[0].per_axis && lane_res[1].neg;
	assign nc = !lane_res[0].per_axis && lane_res[2].neg;

	always_comb begin
		priority if (na)
			status = dik_pkg::REACH_A;
		else if (nb)
			status = dik_pkg::REACH_B;
		else if (nc)
			status = dik_pkg::REACH_C;
		else
			status = dik_pkg::REACH_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_q[dik_pkg::PipeDepth-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			steps_a_q <= na ? '0 : lane_res[0].steps;
			steps_b_q <= (na || nb) ? '0 : lane_res[1].steps;
			steps_c_q <= (na || nb || nc) ? '0 : lane_res[2].steps;
			status_q  <= status;
		end
	end

	assign steps_out.valid        = out_valid_q;
	assign steps_out.steps_a      = steps_a_q;
	assign steps_out.steps_b      = steps_b_q;
	assign steps_out.steps_c      = steps_c_q;
	assign steps_out.reach_status = status_q;

endmodule

@@ hdl/dik_checker.sv @@
// ----------------------------------------------------------------------------
// dik_checker
// Port-level checks on the step output of the kinematics unit.
// ----------------------------------------------------------------------------
module dik_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [dik_pkg::StepsW-1:0] steps_a,
	input logic signed [dik_pkg::StepsW-1:0] steps_b,
	input logic signed [dik_pkg::StepsW-1:0] steps_c,
	input logic [1:0]                        reach_status
);

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(steps_a) && $stable(steps_b)
			&& $stable(steps_c) && $stable(reach_status))
		else $error("output word changed while stalled");

	a_zero_a: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reach_status == dik_pkg::REACH_A |->
			steps_a == '0 && steps_b == '0 && steps_c == '0)
		else $error("towers from A on not zero");

	a_zero_b: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reach_status == dik_pkg::REACH_B |-> steps_b == '0 && steps_c == '0)
		else $error("towers from B on not zero");

	a_zero_c: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reach_status == dik_pkg::REACH_C |-> steps_c == '0)
		else $error("tower C not zero");

endmodule

bind delta_inverse_kinematics_steps_unit dik_checker u_dik_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (steps_out.valid),
	.out_ready   (steps_out.ready),
	.steps_a     (steps_out.steps_a),
	.steps_b     (steps_out.steps_b),
	.steps_c     (steps_out.steps_c),
	.reach_status(steps_out.reach_status)
);
